FILE: src/fcr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

  // default radicand width
  localparam int RADICAND_BITS_DEFAULT = 32;

  // width of the root field on the port
  localparam int ROOT_WIDTH = 11;

  // one root bit per three radicand bits, rounded up
  localparam int ROOT_BITS_DEFAULT = (RADICAND_BITS_DEFAULT + 2) / 3;

endpackage

`default_nettype wire

FILE: src/floor_cube_root_core.sv
`timescale 1ns / 1ps
`default_nettype none

// floor cube root: takes one unsigned radicand per word and returns the largest
// integer r with r*r*r not above it, exact for every input (perfect cubes included).
// the work runs down a row of ceil(RADICAND_BITS/3) cells, one root bit per cell,
// each cell registering its result, and a new radicand can enter in every cycle
// while the output is not held. the last cell is the output register; while it
// holds a word that root_stall refuses, the whole row freezes and radicand_stall
// is raised. if the parameter makes the root wider than the root port, the port
// carries its low bits.

module floor_cube_root_core #(
  parameter int RADICAND_BITS = fcr_pkg::RADICAND_BITS_DEFAULT
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     radicand_valid,
  output logic                          radicand_stall,
  input  wire logic [RADICAND_BITS-1:0] radicand,
  output logic                          root_valid,
  input  wire logic                     root_stall,
  output logic [fcr_pkg::ROOT_WIDTH-1:0] root
);

  // cells in the row, one per root bit
  localparam int RootBits = (RADICAND_BITS + 2) / 3;
  localparam int SqBits   = 2 * RootBits;
  localparam int RemBits  = 3 * RootBits;
  localparam int ExtBits  = RootBits + fcr_pkg::ROOT_WIDTH;

  // stage 0 is the incoming word, stage RootBits the output register
  logic [RootBits:0]  valid_v;
  logic [RootBits-1:0] y_s   [0:RootBits];
  logic [SqBits-1:0]   ysq_s [0:RootBits];
  logic [RemBits-1:0]  rem_s [0:RootBits];

  logic en;
  logic [ExtBits-1:0] root_ext;

  // the row moves unless a finished word is held by the consumer
  assign en             = !(valid_v[RootBits] && root_stall);
  assign radicand_stall = !en;

  // partial root and its square start at zero, remainder is the radicand
  assign valid_v[0] = radicand_valid;
  assign y_s[0]     = '0;
  assign ysq_s[0]   = '0;
  assign rem_s[0]   = RemBits'(radicand);

  for (genvar k = 0; k < RootBits; k++) begin : g_cell
    fcr_cell #(
      .RootBits (RootBits),
      .Stage    (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .prev_valid (valid_v[k]),
      .prev_y     (y_s[k]),
      .prev_ysq   (ysq_s[k]),
      .prev_rem   (rem_s[k]),
      .valid      (valid_v[k+1]),
      .y          (y_s[k+1]),
      .ysq        (ysq_s[k+1]),
      .rem        (rem_s[k+1])
    );
  end

  // root port carries the low bits of the full root
  assign root_ext   = ExtBits'(y_s[RootBits]);
  assign root       = root_ext[fcr_pkg::ROOT_WIDTH-1:0];
  assign root_valid = valid_v[RootBits];

  // an accepted radicand lands in the first cell
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (radicand_valid && !radicand_stall) |=> valid_v[1])
    else $error("floor_cube_root_core: accepted word lost at entry");

  // a held output freezes every cell
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    (root_valid && root_stall) |=> $stable(valid_v[RootBits:1]))
    else $error("floor_cube_root_core: row moved while output held");

endmodule

`default_nettype wire

FILE: src/fcr_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module fcr_cell #(
  parameter int RootBits = fcr_pkg::ROOT_BITS_DEFAULT,
  parameter int Stage    = 0
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  prev_valid,
  input  wire logic [RootBits-1:0]   prev_y,
  input  wire logic [2*RootBits-1:0] prev_ysq,
  input  wire logic [3*RootBits-1:0] prev_rem,
  output logic                       valid,
  output logic [RootBits-1:0]        y,
  output logic [2*RootBits-1:0]      ysq,
  output logic [3*RootBits-1:0]      rem
);

  localparam int SqBits   = 2 * RootBits;
  localparam int RemBits  = 3 * RootBits;
  localparam int WideBits = RemBits + 4;
  localparam int Shift    = 3 * (RootBits - 1 - Stage);

  logic [WideBits-1:0] rem_w;
  logic [WideBits-1:0] y_w;
  logic [WideBits-1:0] ysq_w;
  logic [WideBits-1:0] bound;
  logic [WideBits-1:0] top;
  logic [WideBits-1:0] sub;
  logic                take;

  logic [RootBits-1:0] y_next;
  logic [SqBits-1:0]   ysq_next;
  logic [RemBits-1:0]  rem_next;

  assign rem_w = WideBits'(prev_rem);
  assign y_w   = WideBits'(prev_y);
  assign ysq_w = WideBits'(prev_ysq);

  // 3*(2y)*(2y+1)+1 = 12*y^2 + 6*y + 1, shifts and adds only
  assign bound = (ysq_w << 3) + (ysq_w << 2) + (y_w << 2) + (y_w << 1) + WideBits'(1);
  assign top   = rem_w >> Shift;
  assign take  = top >= bound;
  assign sub   = rem_w - (bound << Shift);

  always_comb begin
    if (take) begin
      y_next   = RootBits'((y_w << 1) | WideBits'(1));
      ysq_next = SqBits'((ysq_w << 2) + (y_w << 2) + WideBits'(1));
      rem_next = RemBits'(sub);
    end else begin
      y_next   = RootBits'(y_w << 1);
      ysq_next = SqBits'(ysq_w << 2);
      rem_next = prev_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y   <= y_next;
      ysq <= ysq_next;
      rem <= rem_next;
    end
  end

  // invariant checks
  logic [WideBits-1:0] chk_y;
  logic [WideBits-1:0] chk_sq;
  logic [WideBits-1:0] chk_top;
  logic [WideBits-1:0] chk_lim;

  assign chk_y   = WideBits'(y);
  assign chk_sq  = WideBits'(ysq);
  assign chk_top = WideBits'(rem) >> Shift;
  assign chk_lim = (chk_sq << 1) + chk_sq + (chk_y << 1) + chk_y;

  // square tracker stays the square of the partial root
  a_square: assert property (@(posedge clk) disable iff (rst)
    valid |-> chk_sq == chk_y * chk_y)
    else $error("fcr_cell: square tracker out of step");

  // remainder is below the gap to the next cube
  a_remainder: assert property (@(posedge clk) disable iff (rst)
    valid |-> chk_top <= chk_lim)
    else $error("fcr_cell: remainder not reduced");

endmodule

`default_nettype wire

FILE: dv/cube_root_checker.sv
`timescale 1ns / 1ps

// watches both channels, predicts each root and compares in order
module cube_root_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           radicand_valid,
  input  wire logic                           radicand_stall,
  input  wire logic [fcr_pkg::RADICAND_BITS_DEFAULT-1:0] radicand,
  input  wire logic                           root_valid,
  input  wire logic                           root_stall,
  input  wire logic [fcr_pkg::ROOT_WIDTH-1:0] root,
  output int                                  errors,
  output int                                  pending
);
  import fcr_pkg::*;

  typedef struct packed {
    logic [RADICAND_BITS_DEFAULT-1:0] operand;
    logic [ROOT_WIDTH-1:0]            floor_root;
  } root_entry_t;

  root_entry_t expected_roots [$];
  root_entry_t oldest;

  initial errors = 0;
  assign pending = expected_roots.size();

  // restoring cube root, one root bit per group of three operand bits
  function automatic logic [ROOT_WIDTH-1:0] floor_cube_root(input logic [63:0] operand);
    logic [63:0] remainder;
    logic [63:0] partial;
    logic [63:0] step_term;
    remainder = operand;
    partial   = '0;
    for (int shift = 63; shift >= 0; shift -= 3) begin
      partial   = partial << 1;
      step_term = 64'd3 * partial * (partial + 64'd1) + 64'd1;
      if ((remainder >> shift) >= step_term) begin
        remainder = remainder - (step_term << shift);
        partial   = partial + 64'd1;
      end
    end
    return partial[ROOT_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (radicand_valid && !radicand_stall)
        expected_roots.push_back('{radicand, floor_cube_root(64'(radicand))});
      if (root_valid && !root_stall) begin
        if (expected_roots.size() == 0) begin
          $display("%0t: unexpected root word, expected none, actual %0d", $time, root);
          errors <= errors + 1;
        end else begin
          oldest = expected_roots.pop_front();
          if (root !== oldest.floor_root) begin
            $display("%0t: root of %0d, expected %0d, actual %0d",
                     $time, oldest.operand, oldest.floor_root, root);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

// drives radicand words into the cube root core with random gaps, takes root
// words with random stalls, and leaves all prediction to the checker
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;  // idle cycles before giving up
  localparam int DRAIN_CYCLES   = 30;    // pipeline depth is 11 at 32 bits
  localparam int RANDOM_WORDS   = 500;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            radicand_valid = 1'b0;
  logic [fcr_pkg::RADICAND_BITS_DEFAULT-1:0] radicand = '0;
  logic                            root_stall = 1'b0;
  logic                            radicand_stall;
  logic                            root_valid;
  logic [fcr_pkg::ROOT_WIDTH-1:0]  root;

  int          errors;
  int          pending;
  int          idle_cycles = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold;
  bit          send_quiet = 1'b0;   // sender runs back to back while set
  bit          take_quiet = 1'b0;   // receiver never stalls while set

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  floor_cube_root_core uut (
    .clk            (clk),
    .rst            (rst),
    .radicand_valid (radicand_valid),
    .radicand_stall (radicand_stall),
    .radicand       (radicand),
    .root_valid     (root_valid),
    .root_stall     (root_stall),
    .root           (root)
  );

  cube_root_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .radicand_valid (radicand_valid),
    .radicand_stall (radicand_stall),
    .radicand       (radicand),
    .root_valid     (root_valid),
    .root_stall     (root_stall),
    .root           (root),
    .errors         (errors),
    .pending        (pending)
  );

  // receiver: after each root word taken, stall for a randomly drawn hold; now and then
  // switch into a quiet stretch where it takes every word at once
  always @(posedge clk) begin
    next_hold = hold_left;
    if (rst) begin
      next_hold = 0;
    end else if (root_valid && !root_stall) begin
      if ($urandom_range(0, 39) == 0)
        take_quiet = !take_quiet;
      next_hold = take_quiet ? 0 : $urandom_range(0, 6);
    end else if (next_hold != 0) begin
      next_hold = next_hold - 1;
    end
    hold_left  <= next_hold;
    root_stall <= (next_hold != 0);
  end

  // watchdog on cycles where neither channel moves a word
  always @(posedge clk) begin
    if (rst || (radicand_valid && !radicand_stall) || (root_valid && !root_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one radicand word: optional gap with valid low, then hold until taken;
  // valid stays high after the handshake so back-to-back words need no dip
  task automatic send_word(input logic [fcr_pkg::RADICAND_BITS_DEFAULT-1:0] value);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      radicand_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    radicand_valid <= 1'b1;
    radicand       <= value;
    do @(posedge clk); while (radicand_stall);
  endtask

  initial begin
    logic [63:0] cube;
    int unsigned base_root;
    int unsigned width;
    logic [fcr_pkg::RADICAND_BITS_DEFAULT-1:0] value;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // corners: zero, smallest cubes and their neighbors, all ones,
    // the largest cube that fits, alternating bit patterns
    send_word(32'd0);
    send_word(32'd1);
    send_word(32'd7);
    send_word(32'd8);
    send_word(32'd26);
    send_word(32'd27);
    send_word(32'd63);
    send_word(32'd64);
    send_word(32'd999999999);
    send_word(32'd1000000000);
    send_word(32'd1073741823);
    send_word(32'd1073741824);
    send_word(32'd4283098624);   // 1624 cubed
    send_word(32'd4291015624);   // one below 1625 cubed
    send_word(32'd4291015625);   // 1625 cubed
    send_word(32'd4291015626);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'hAAAA_AAAA);
    send_word(32'h5555_5555);

    // random part: perfect cubes and their neighbors, full-width noise,
    // and short values that keep the root small
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 39) == 0)
        send_quiet = !send_quiet;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          base_root = $urandom_range(0, 1625);
          cube      = 64'(base_root) * 64'(base_root) * 64'(base_root);
          cube      = cube + 64'($urandom_range(0, 2)) - 64'd1;
          value     = cube[fcr_pkg::RADICAND_BITS_DEFAULT-1:0];
        end
        4, 5, 6: value = $urandom();
        default: begin
          width = $urandom_range(1, fcr_pkg::RADICAND_BITS_DEFAULT);
          cube  = (64'd1 << width) - 64'd1;
          value = $urandom() & cube[fcr_pkg::RADICAND_BITS_DEFAULT-1:0];
        end
      endcase
      send_word(value);
    end
    radicand_valid <= 1'b0;

    // let every predicted root come out, then give the pipe time to settle
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
